// File: design/skf_pkg.sv
// shared types and constants for the scalar kalman smoother
`timescale 1ns / 1ps

package skf_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned AluW   = 34;
    localparam int unsigned GainW  = 17;
    localparam int unsigned SdW    = 24;
    localparam int unsigned CntW   = 5;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned OutW   = 112;

    // division produces one quotient bit per step, the root one bit per step
    localparam logic [CntW-1:0] DivLast  = CntW'(GainW - 1);
    localparam logic [CntW-1:0] SqrtLast = CntW'(SdW - 1);

    localparam logic [DataW-1:0] InitEstRst = 32'd75366400;
    localparam logic [DataW-1:0] InitVarRst = 32'd32768000;
    localparam logic [DataW-1:0] ProcNoiseRst = 32'd65536;
    localparam logic [DataW-1:0] MeasNoiseRst = 32'd14745600;
    localparam logic [GainW-1:0] GainOne = 17'h10000;

    localparam logic [CfgIdxW-1:0] CfgInitEst   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgInitVar   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgProcNoise = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgMeasNoise = 2'd3;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_PRED  = 12'b0000_0000_0010,
        ST_DEN   = 12'b0000_0000_0100,
        ST_DIV   = 12'b0000_0000_1000,
        ST_INNOV = 12'b0000_0001_0000,
        ST_MAG   = 12'b0000_0010_0000,
        ST_MUL1  = 12'b0000_0100_0000,
        ST_CORR  = 12'b0000_1000_0000,
        ST_VAR   = 12'b0001_0000_0000,
        ST_SQRT  = 12'b0010_0000_0000,
        ST_FIN   = 12'b0100_0000_0000,
        ST_SPARE = 12'b1000_0000_0000
    } t_state;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_state st;
        logic   load_out;
    } t_seq;

endpackage

// File: design/skf_alu.sv
// shared add/subtract unit with borrow out
`timescale 1ns / 1ps

module skf_alu (
    input  skf_pkg::t_alu_op            i_op,
    input  logic [skf_pkg::AluW-1:0]    i_a,
    input  logic [skf_pkg::AluW-1:0]    i_b,
    output logic [skf_pkg::AluW-1:0]    o_res,
    output logic                        o_borrow
);

    logic [skf_pkg::AluW:0]   sum;
    logic [skf_pkg::AluW-1:0] b_eff;
    logic                     is_sub;

    assign is_sub = (i_op == skf_pkg::ALU_SUB);
    assign b_eff  = is_sub ? ~i_b : i_b;
    assign sum    = {1'b0, i_a} + {1'b0, b_eff} + {{skf_pkg::AluW{1'b0}}, is_sub};

    assign o_res    = sum[skf_pkg::AluW-1:0];
    // a subtract borrows when there is no carry out
    assign o_borrow = is_sub & ~sum[skf_pkg::AluW];

endmodule

// File: design/skf_ctrl.sv
// step sequencer for the scalar kalman smoother
`timescale 1ns / 1ps

module skf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_out_free,
    output skf_pkg::t_seq  o_seq
);

    skf_pkg::t_state           r_st, n_st;
    logic [skf_pkg::CntW-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        case (r_st)
            skf_pkg::ST_IDLE: begin
                if (i_start) n_st = skf_pkg::ST_PRED;
            end
            skf_pkg::ST_PRED:  n_st = skf_pkg::ST_DEN;
            skf_pkg::ST_DEN: begin
                n_st  = skf_pkg::ST_DIV;
                n_cnt = skf_pkg::DivLast;
            end
            skf_pkg::ST_DIV: begin
                if (r_cnt == '0) n_st = skf_pkg::ST_INNOV;
                else n_cnt = r_cnt - 1'b1;
            end
            skf_pkg::ST_INNOV: n_st = skf_pkg::ST_MAG;
            skf_pkg::ST_MAG:   n_st = skf_pkg::ST_MUL1;
            skf_pkg::ST_MUL1:  n_st = skf_pkg::ST_CORR;
            skf_pkg::ST_CORR:  n_st = skf_pkg::ST_VAR;
            skf_pkg::ST_VAR: begin
                n_st  = skf_pkg::ST_SQRT;
                n_cnt = skf_pkg::SqrtLast;
            end
            skf_pkg::ST_SQRT: begin
                if (r_cnt == '0) n_st = skf_pkg::ST_FIN;
                else n_cnt = r_cnt - 1'b1;
            end
            skf_pkg::ST_FIN: begin
                if (i_out_free) n_st = skf_pkg::ST_IDLE;
            end
            default: n_st = skf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= skf_pkg::ST_IDLE;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
    end

    assign o_seq.st       = r_st;
    assign o_seq.load_out = (r_st == skf_pkg::ST_FIN) && i_out_free;

endmodule

// File: design/scalar_kalman_smoother.sv
// top level of the scalar kalman smoother: registers, datapath and output beat
`timescale 1ns / 1ps

// One-dimensional Kalman filter over a stream of Q16.16 measurements.
// Slave stream: s_axis_tdata carries the measurement, s_axis_tuser[0] the
// restart flag that reloads estimate and variance from the init registers.
// Master stream: one result beat per input beat with estimate, variance,
// square-root deviation and the gain used.
// The block takes one beat at a time: s_axis_tready is high only while idle.
// After a beat is taken the result passes through prediction, denominator,
// 17 divider steps, five update steps, 24 root steps and the output load,
// and only then can a new beat be taken. The pace is set by the one
// shared add/subtract unit, which the divider, the estimate update and the
// bit-serial square root all go through in turn.
// A result waits in the output register while m_axis_tready is low; the
// sequencer holds in its last step until the register is free.
// Configuration writes go through i_cfg_wr_en/i_cfg_idx/i_cfg_wdata; the user
// must make them only while idle; the block does not enforce it. Synchronous
// reset restores register defaults and loads estimate and variance from them.

module scalar_kalman_smoother (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [skf_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [skf_pkg::DataW-1:0]    i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [skf_pkg::DataW-1:0]    s_axis_tdata,   // measurement
    input  logic [0:0]                   s_axis_tuser,   // restart
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // estimate, variance_out, std_dev, gain, zero fill
    output logic [skf_pkg::OutW-1:0]     m_axis_tdata
);

    localparam int unsigned DW = skf_pkg::DataW;
    localparam int unsigned AW = skf_pkg::AluW;
    localparam int unsigned GW = skf_pkg::GainW;
    localparam int unsigned SW = skf_pkg::SdW;

    skf_pkg::t_seq    seq;
    skf_pkg::t_alu_op alu_op;
    logic [AW-1:0]    alu_a, alu_b, alu_res;
    logic             alu_borrow;
    logic             accept, out_free;

    logic [DW-1:0] r_init_est, r_init_var, r_pn, r_mn;
    logic [DW-1:0] r_est, r_var, r_meas, r_vp;
    logic [DW:0]   r_den;
    logic [AW-1:0] r_rem, r_inn;
    logic [GW-1:0] r_quot, r_gain, r_omg;
    logic [DW:0]   r_mag;
    logic          r_neg;
    logic [DW+GW:0] r_prod;
    logic [2*SW-1:0] r_sq;
    logic [SW+1:0] r_srem;
    logic [SW-1:0] r_root;

    logic [DW-1:0] r_o_est, r_o_var;
    logic [SW-1:0] r_o_sd;
    logic [GW-1:0] r_o_gain;
    logic          r_ovalid;

    logic [DW:0]     mul_a;
    logic [GW-1:0]   mul_b;
    logic [SW+3:0]   sq_cur;
    logic [SW+1:0]   sq_trial;
    logic [DW:0]     div_keep;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (seq.st == skf_pkg::ST_IDLE);

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_free (out_free),
        .o_seq      (seq)
    );

    skf_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    // next two bits of the radicand appended to the partial remainder
    assign sq_cur   = {r_srem, r_sq[2*SW-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};
    assign div_keep = alu_borrow ? r_rem[DW:0] : alu_res[DW:0];

    always_comb begin
        alu_op = skf_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (seq.st)
            skf_pkg::ST_PRED: begin
                alu_a = {2'b00, r_var};
                alu_b = {2'b00, r_pn};
            end
            skf_pkg::ST_DEN: begin
                alu_a = {2'b00, r_vp};
                alu_b = {2'b00, r_mn};
            end
            skf_pkg::ST_DIV: begin
                alu_op = skf_pkg::ALU_SUB;
                alu_a  = r_rem;
                alu_b  = {1'b0, r_den};
            end
            skf_pkg::ST_INNOV: begin
                alu_op = skf_pkg::ALU_SUB;
                alu_a  = {{2{r_meas[DW-1]}}, r_meas};
                alu_b  = {{2{r_est[DW-1]}}, r_est};
            end
            skf_pkg::ST_MAG: begin
                alu_op = skf_pkg::ALU_SUB;
                alu_a  = '0;
                alu_b  = r_inn;
            end
            skf_pkg::ST_MUL1: begin
                alu_op = skf_pkg::ALU_SUB;
                alu_a  = {{(AW-GW){1'b0}}, skf_pkg::GainOne};
                alu_b  = {{(AW-GW){1'b0}}, r_gain};
            end
            skf_pkg::ST_CORR: begin
                alu_op = r_neg ? skf_pkg::ALU_SUB : skf_pkg::ALU_ADD;
                alu_a  = {{2{r_est[DW-1]}}, r_est};
                alu_b  = {1'b0, r_prod[DW+16:16]};
            end
            skf_pkg::ST_SQRT: begin
                alu_op = skf_pkg::ALU_SUB;
                alu_a  = {{(AW-SW-4){1'b0}}, sq_cur};
                alu_b  = {{(AW-SW-2){1'b0}}, sq_trial};
            end
            default: begin
                alu_op = skf_pkg::ALU_ADD;
            end
        endcase
    end

    // one multiplier: innovation times gain, then predicted variance times one minus gain
    always_comb begin
        if (seq.st == skf_pkg::ST_CORR) begin
            mul_a = {1'b0, r_vp};
            mul_b = r_omg;
        end else begin
            mul_a = r_mag;
            mul_b = r_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_est <= skf_pkg::InitEstRst;
            r_init_var <= skf_pkg::InitVarRst;
            r_pn       <= skf_pkg::ProcNoiseRst;
            r_mn       <= skf_pkg::MeasNoiseRst;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                skf_pkg::CfgInitEst:   r_init_est <= i_cfg_wdata;
                skf_pkg::CfgInitVar:   r_init_var <= i_cfg_wdata;
                skf_pkg::CfgProcNoise: r_pn       <= i_cfg_wdata;
                skf_pkg::CfgMeasNoise: r_mn       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= skf_pkg::InitEstRst;
            r_var <= skf_pkg::InitVarRst;
        end else if (accept && s_axis_tuser[0]) begin
            r_est <= r_init_est;
            r_var <= r_init_var;
        end else if (seq.st == skf_pkg::ST_CORR) begin
            r_est <= alu_res[DW-1:0];
        end else if (seq.st == skf_pkg::ST_VAR) begin
            r_var <= r_prod[DW+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_meas <= s_axis_tdata;
        case (seq.st)
            skf_pkg::ST_PRED: begin
                // saturate the predicted variance
                r_vp <= alu_res[DW] ? {DW{1'b1}} : alu_res[DW-1:0];
            end
            skf_pkg::ST_DEN: begin
                r_den <= alu_res[DW:0];
                r_rem <= {2'b00, r_vp};
            end
            skf_pkg::ST_DIV: begin
                r_quot <= {r_quot[GW-2:0], ~alu_borrow};
                r_rem  <= {div_keep, 1'b0};
            end
            skf_pkg::ST_INNOV: begin
                r_inn  <= alu_res;
                r_gain <= (r_den == '0) ? '0 : r_quot;
            end
            skf_pkg::ST_MAG: begin
                r_neg <= r_inn[AW-1];
                r_mag <= r_inn[AW-1] ? alu_res[DW:0] : r_inn[DW:0];
            end
            skf_pkg::ST_MUL1: begin
                r_omg  <= alu_res[GW-1:0];
                r_prod <= mul_a * mul_b;
            end
            skf_pkg::ST_CORR: begin
                r_prod <= mul_a * mul_b;
            end
            skf_pkg::ST_VAR: begin
                r_sq   <= {r_prod[DW+15:16], 16'b0};
                r_srem <= '0;
                r_root <= '0;
            end
            skf_pkg::ST_SQRT: begin
                r_sq <= {r_sq[2*SW-3:0], 2'b00};
                if (alu_borrow) begin
                    r_srem <= sq_cur[SW+1:0];
                    r_root <= {r_root[SW-2:0], 1'b0};
                end else begin
                    r_srem <= alu_res[SW+1:0];
                    r_root <= {r_root[SW-2:0], 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (seq.load_out) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq.load_out) begin
            r_o_est  <= r_est;
            r_o_var  <= r_var;
            r_o_sd   <= r_root;
            r_o_gain <= r_gain;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(skf_pkg::OutW-2*DW-SW-GW){1'b0}},
                            r_o_gain, r_o_sd, r_o_var, r_o_est};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("block took a beat while still working");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_o_gain <= skf_pkg::GainOne))
        else $error("gain above one");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq.st == skf_pkg::ST_FIN) && r_ovalid && !m_axis_tready
        |=> (seq.st == skf_pkg::ST_FIN))
        else $error("result finished while output register was full");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq.load_out |=> r_ovalid)
        else $error("output load lost");
`endif

endmodule
